// ===== src/histeq_pkg.sv =====
// Shared types and constants of the histogram equalizer.
package histeq_pkg;

	localparam int LEVELS = 256;
	localparam int LVL_W = $clog2(LEVELS);
	localparam int PIX_W = 8;
	localparam int CMD_W = 2;
	localparam int BIN_W = 22;
	localparam int MAP_W = 8;
	localparam int QUO_W = 8;
	localparam int STEP_W = $clog2(QUO_W);
	localparam int PROD_W = BIN_W + QUO_W;

	localparam longint unsigned MAX_PIXELS = 64'd4194303;
	localparam longint unsigned COUNT_MAX = (64'd1 << BIN_W) - 64'd1;
	localparam logic [BIN_W-1:0] COUNT_LIMIT =
		BIN_W'((MAX_PIXELS > COUNT_MAX) ? COUNT_MAX : MAX_PIXELS);

	typedef enum logic [CMD_W-1:0] {
		CMD_ACCUM = 2'd0,
		CMD_BUILD = 2'd1,
		CMD_REMAP = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [BIN_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== src/histeq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module histeq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/histeq_div.sv =====
// Restoring divider that yields one quotient bit per cycle for the map build.
module histeq_div import histeq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [PROD_W-1:0] rem_q;
	logic [BIN_W-1:0]  dvs_q;
	logic [QUO_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic              run_q;
	logic              done_q;
	logic [PROD_W-1:0] shifted;
	logic              fits;

	// The quotient is known to fit in QUO_W bits, so the divisor starts
	// at its highest shift and walks down one position per cycle.
	assign shifted = {{(PROD_W-BIN_W){1'b0}}, dvs_q} << step_q;
	assign fits = (rem_q >= shifted);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= run_q && (step_q == '0);
			if (req.start) begin
				run_q <= 1'b1;
				step_q <= STEP_W'(QUO_W - 1);
			end else if (run_q) begin
				if (step_q == '0) begin
					run_q <= 1'b0;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
			dvs_q <= req.divisor;
			quo_q <= '0;
		end else if (run_q) begin
			if (fits) begin
				rem_q <= rem_q - shifted;
			end
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== src/histogram_equalizer.sv =====
// Top level of the two-pass histogram equalizer for 8-bit grayscale pixels.
//
//  Channel   Direction  Handshake                 Payload
//  command   in         start high, busy low      cmd, pixel
//  result    out        done pulse, one cycle     mapped_pixel
//
// Accumulate (cmd 0) and remap (cmd 2) items are taken one per cycle while busy is low. An
// accumulate item reads its bin in the cycle it is accepted and writes the
// incremented count back from the acc_s1 stage; a write that lands on the same
// bin as the following item's read is forwarded from a last-write register.
// A remap item reads the map memory when accepted, and its result shows on
// mapped_pixel with done high in the next cycle. The receiver cannot stall.
// A build (cmd 1) holds busy while each level passes the bin memory read,
// accumulate, divider start, one-bit-per-cycle divide and map write states.
// Reset clears the bin valid bits, the pixel count and the map flag, so the
// histogram and the map read as zero without a clearing pass.
module histogram_equalizer import histeq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [CMD_W-1:0] cmd,
	input  logic [PIX_W-1:0] pixel,
	output logic             done,
	output logic [MAP_W-1:0] mapped_pixel
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_ACC,
		ST_START,
		ST_DIV,
		ST_WRITE
	} state_t;

	state_t           state_q;
	logic [LVL_W-1:0] lvl_q;
	logic [BIN_W-1:0] cdf_q;
	logic [BIN_W-1:0] pixel_count_q;
	logic [LEVELS-1:0] bin_vld_q;
	logic             map_built_q;

	cmd_t             cmd_e;
	logic             accept;
	logic             acc_go;

	// Accumulate stage and last-write record for forwarding.
	logic             acc_s1;
	logic [LVL_W-1:0] pix_s1;
	logic             rmp_s1;
	logic             wr_vld_q;
	logic [LVL_W-1:0] wr_addr_q;
	logic [BIN_W-1:0] wr_data_q;
	logic [BIN_W-1:0] bin_old;
	logic [BIN_W-1:0] bin_new;

	logic [LVL_W-1:0] bin_raddr;
	logic [BIN_W-1:0] bin_rdata;
	logic [BIN_W-1:0] bin_level;
	logic             map_we;
	logic [MAP_W-1:0] map_wdata;
	logic [MAP_W-1:0] map_rdata;

	div_req_t         div_req;
	div_rsp_t         div_rsp;

	assign cmd_e = cmd_t'(cmd);
	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	// A pixel that arrives with the count at its limit is dropped entirely,
	// so no bin can ever exceed the count.
	assign acc_go = accept && (cmd_e == CMD_ACCUM) && (pixel_count_q < COUNT_LIMIT);

	// The build walk owns the bin read port; otherwise it follows the pixel.
	assign bin_raddr = (state_q == ST_READ) ? lvl_q : LVL_W'(pixel);
	assign bin_level = bin_vld_q[lvl_q] ? bin_rdata : '0;

	always_comb begin
		if (wr_vld_q && (wr_addr_q == pix_s1)) begin
			bin_old = wr_data_q;
		end else if (bin_vld_q[pix_s1]) begin
			bin_old = bin_rdata;
		end else begin
			bin_old = '0;
		end
	end
	assign bin_new = bin_old + 1'b1;

	// cdf * 255 is formed as cdf * 256 - cdf and handed to the divider.
	assign div_req.start = (state_q == ST_START);
	assign div_req.dividend = {cdf_q, {QUO_W{1'b0}}} - {{QUO_W{1'b0}}, cdf_q};
	assign div_req.divisor = pixel_count_q;

	// An empty frame maps every level to zero.
	assign map_we = (state_q == ST_WRITE);
	assign map_wdata = (pixel_count_q == '0) ? '0 : MAP_W'(div_rsp.quotient);

	histeq_ram #(
		.WIDTH(BIN_W),
		.DEPTH(LEVELS)
	) u_bin_ram (
		.clk  (clk),
		.we   (acc_s1),
		.waddr(pix_s1),
		.wdata(bin_new),
		.raddr(bin_raddr),
		.rdata(bin_rdata)
	);

	histeq_ram #(
		.WIDTH(MAP_W),
		.DEPTH(LEVELS)
	) u_map_ram (
		.clk  (clk),
		.we   (map_we),
		.waddr(lvl_q),
		.wdata(map_wdata),
		.raddr(LVL_W'(pixel)),
		.rdata(map_rdata)
	);

	histeq_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// Build sequencer together with the count, the bin valid bits and the map flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lvl_q <= '0;
			cdf_q <= '0;
			pixel_count_q <= '0;
			bin_vld_q <= '0;
			map_built_q <= 1'b0;
		end else begin
			if (acc_s1) begin
				bin_vld_q[pix_s1] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc_go) begin
						pixel_count_q <= pixel_count_q + 1'b1;
					end
					if (accept && (cmd_e == CMD_BUILD)) begin
						lvl_q <= '0;
						cdf_q <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					cdf_q <= cdf_q + bin_level;
					state_q <= ST_START;
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (lvl_q == LVL_W'(LEVELS - 1)) begin
						// Last level written: the histogram and count start over.
						pixel_count_q <= '0;
						bin_vld_q <= '0;
						map_built_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						lvl_q <= lvl_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1 <= 1'b0;
			rmp_s1 <= 1'b0;
			wr_vld_q <= 1'b0;
		end else begin
			acc_s1 <= acc_go;
			rmp_s1 <= accept && (cmd_e == CMD_REMAP);
			wr_vld_q <= acc_s1;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= LVL_W'(pixel);
		wr_addr_q <= pix_s1;
		wr_data_q <= bin_new;
	end

	// Until the first build the map reads as all zero.
	assign done = rmp_s1;
	assign mapped_pixel = map_built_q ? map_rdata : '0;

	// A result only ever follows an accepted remap item.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && (cmd == CMD_REMAP)))
		else $error("result without a remap item");

	// No bin write is outstanding while the build walk uses the bin memory.
	assert property (@(posedge clk) disable iff (!arst_n)
		acc_s1 |-> (state_q == ST_IDLE))
		else $error("bin write during map build");

	// The pixel count never passes its limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		pixel_count_q <= COUNT_LIMIT)
		else $error("pixel count above limit");

	// Every map write follows a finished division.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> $past(div_rsp.done))
		else $error("map written before division finished");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the two-pass histogram equalizer.
module tb;
	import histeq_pkg::*;

	// The run ends here no matter what. A build holds the block while it walks all levels.
	// The slowest correct run has a few dozen builds, about 2000 items and random sender
	// gaps, so it stays well under this limit.
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_ITEMS = 2000;
	localparam int QUIET_TAIL = 300;
	localparam int MAX_PRINTED = 40;

	// These shapes decide how pixels spread over the bins within one frame.
	typedef enum int {
		SHAPE_FLAT,
		SHAPE_BAND,
		SHAPE_SPIKE,
		SHAPE_PAIR
	} frame_shape_t;

	// The scoreboard holds its own copy of the histogram, the pixel count and
	// the intensity map. It keeps the mapped values still owed by the block
	// in arrival order.
	class remap_scoreboard;
		logic [BIN_W-1:0] bin_hist [LEVELS];
		logic [BIN_W-1:0] frame_pixels;
		logic [MAP_W-1:0] eq_map [LEVELS];
		logic [MAP_W-1:0] owed_maps [$];
		int errors;

		function new();
			foreach (bin_hist[k]) begin
				bin_hist[k] = '0;
				eq_map[k] = '0;
			end
			frame_pixels = '0;
			errors = 0;
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= MAX_PRINTED) begin
				$display("%0t ns: %s", $realtime, msg);
			end
		endtask

		// Apply one accepted item to the state copy.
		function void take_pixel_item(cmd_t op, logic [PIX_W-1:0] pix);
			longint unsigned cdf;
			longint unsigned total;
			longint unsigned level;
			case (op)
				CMD_ACCUM: begin
					// A full count drops the pixel entirely, so no bin can
					// get ahead of the count.
					if (frame_pixels < COUNT_LIMIT) begin
						bin_hist[pix] = bin_hist[pix] + 1'b1;
						frame_pixels = frame_pixels + 1'b1;
					end
				end
				CMD_BUILD: begin
					cdf = 0;
					total = frame_pixels;
					for (int k = 0; k < LEVELS; k++) begin
						cdf += bin_hist[k];
						level = (total == 0) ? 0 : (cdf * 255) / total;
						if (level > 255) begin
							level = 255;
						end
						eq_map[k] = MAP_W'(level);
						bin_hist[k] = '0;
					end
					frame_pixels = '0;
				end
				CMD_REMAP: owed_maps.push_back(eq_map[pix]);
				default: ;
			endcase
		endfunction

		task check_mapped(logic [MAP_W-1:0] got);
			logic [MAP_W-1:0] want;
			if (owed_maps.size() == 0) begin
				report_mismatch($sformatf("unexpected result, mapped_pixel=%0d", got));
			end else begin
				want = owed_maps.pop_front();
				if (got !== want) begin
					report_mismatch($sformatf("mapped_pixel=%0d, expected %0d", got, want));
				end
			end
		endtask

		function int owed();
			return owed_maps.size();
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [CMD_W-1:0] cmd = CMD_NONE;
	logic [PIX_W-1:0] pixel = '0;
	logic done;
	logic [MAP_W-1:0] mapped_pixel;

	remap_scoreboard sb;
	int cycle_count = 0;
	int items_sent = 0;
	bit gaps_on = 1'b0;

	histogram_equalizer u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.pixel       (pixel),
		.done        (done),
		.mapped_pixel(mapped_pixel)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The watchdog stops a run that hangs. A correct run never gets close.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// The monitor reads the ports right after the rising edge, before any
	// update from that edge lands, so it sees the values the block acted on.
	// A result is checked before the item from the same edge is noted.
	// That item's own result can only come in the next cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				sb.check_mapped(mapped_pixel);
			end
			if (start && !busy) begin
				sb.take_pixel_item(cmd_t'(cmd), pixel);
			end
		end
	end

	// Present one item and hold it until the block takes it. This is entered
	// and left on a rising edge. When the item is taken, a random gap may follow.
	task automatic send_item(cmd_t op, logic [PIX_W-1:0] pix);
		start <= 1'b1;
		cmd <= op;
		pixel <= pix;
		do @(posedge clk); while (busy);
		if (op != CMD_NONE) begin
			items_sent++;
		end
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// Stop sending until every remap result has come back.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (sb.owed() != 0) @(posedge clk);
	endtask

	// Pick a pixel that follows the frame's spread, so the histograms come out
	// flat, banded, single-valued or split between two levels.
	function automatic logic [PIX_W-1:0] shaped_pixel(frame_shape_t shape,
			logic [PIX_W-1:0] base, logic [PIX_W-1:0] alt);
		case (shape)
			SHAPE_FLAT: return PIX_W'($urandom_range(0, 255));
			SHAPE_BAND: return base + PIX_W'($urandom_range(0, 15));
			SHAPE_SPIKE: return base;
			default: return ($urandom_range(0, 1) != 0) ? base : alt;
		endcase
	endfunction

	// Each frame is a well-formed pass. Accumulates are mixed with some noise,
	// then comes a build, and then a run of remaps against the new map.
	task automatic run_frame();
		frame_shape_t shape;
		logic [PIX_W-1:0] base;
		logic [PIX_W-1:0] alt;
		int n_accum;
		int n_remap;
		shape = frame_shape_t'($urandom_range(0, 3));
		base = PIX_W'($urandom_range(0, 255));
		alt = PIX_W'($urandom_range(0, 255));
		n_accum = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300)
			: $urandom_range(1, 60);
		if ($urandom_range(0, 11) == 0) begin
			n_accum = 0;
		end
		for (int i = 0; i < n_accum; i++) begin
			// Noise within a frame: unused commands, and remaps that still
			// read the previous frame's map.
			if ($urandom_range(0, 14) == 0) begin
				send_item(($urandom_range(0, 1) != 0) ? CMD_NONE : CMD_REMAP,
					PIX_W'($urandom_range(0, 255)));
			end
			send_item(CMD_ACCUM, shaped_pixel(shape, base, alt));
		end
		send_item(CMD_BUILD, PIX_W'($urandom_range(0, 255)));
		if ($urandom_range(0, 9) == 0) begin
			// A second build in a row sees an empty frame.
			send_item(CMD_BUILD, PIX_W'($urandom_range(0, 255)));
		end
		n_remap = $urandom_range(1, 40);
		for (int i = 0; i < n_remap; i++) begin
			send_item(CMD_REMAP, ($urandom_range(0, 1) != 0)
				? shaped_pixel(shape, base, alt) : PIX_W'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 7) == 0) begin
			drain_results();
		end
	endtask

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		// Reset is released away from the rising edge. This avoids a race with
		// the asynchronous clear.
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. It starts with remaps against the cleared map and a
		// build of an empty frame.
		send_item(CMD_REMAP, 8'h00);
		send_item(CMD_REMAP, 8'hFF);
		send_item(CMD_BUILD, 8'hA5);
		send_item(CMD_NONE, 8'hFF);
		send_item(CMD_REMAP, 8'h80);
		// This small frame hits both extreme bins. Three back-to-back pixels
		// land on the same bin, so the write-back must be forwarded. The
		// unused command carries a pixel that must not be counted.
		send_item(CMD_ACCUM, 8'h00);
		send_item(CMD_ACCUM, 8'hFF);
		send_item(CMD_ACCUM, 8'hFF);
		send_item(CMD_ACCUM, 8'hFF);
		send_item(CMD_ACCUM, 8'h80);
		send_item(CMD_NONE, 8'h80);
		send_item(CMD_BUILD, 8'h5A);
		send_item(CMD_REMAP, 8'h00);
		send_item(CMD_REMAP, 8'h7F);
		send_item(CMD_REMAP, 8'h80);
		send_item(CMD_REMAP, 8'hFE);
		send_item(CMD_REMAP, 8'hFF);
		// A remap in the middle of accumulation still uses the old map.
		send_item(CMD_ACCUM, 8'h07);
		send_item(CMD_REMAP, 8'h07);
		send_item(CMD_BUILD, 8'h00);
		send_item(CMD_REMAP, 8'h07);
		send_item(CMD_REMAP, 8'h06);
		drain_results();
		// A build of an empty frame zeroes the map again.
		send_item(CMD_BUILD, 8'hFF);
		send_item(CMD_REMAP, 8'hFF);

		// Random part. Gaps come and go by phase, and the tail runs at full rate.
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			gaps_on = (items_sent < RANDOM_ITEMS - QUIET_TAIL)
				&& ($urandom_range(0, 3) != 0);
			run_frame();
		end
		gaps_on = 1'b0;

		drain_results();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.owed() == 0) begin
			$display("Test completed successfully");
		end else begin
			if (sb.owed() != 0) begin
				$display("%0d mapped results never arrived", sb.owed());
			end
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
